[src/selective_repeat_sender_window_core_macros.svh]
// Assertion macros used by the window core datapath.
// Needs nothing; included by files that carry assertions.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_CORE_MACROS_SVH

// same-cycle implication
`define SRSW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/srsw_pkg.sv]
// Shared types and constants of the selective-repeat sender window core.
// No dependencies.
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int SEQ_W     = 16;
    localparam int AGE_W     = 16;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

    localparam logic [SEQ_W-1:0] PACKET_COUNT_RST  = 16'd0;
    localparam logic [AGE_W-1:0] TIMEOUT_TICKS_RST = 16'd100;

    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_NOT_SENT = 2'd0,
        ST_SENT     = 2'd1,
        ST_ACKED    = 2'd2
    } t_slot_st;

    typedef struct packed {
        logic clear;
        logic mark;
        logic slide;
        logic walk_new;
        logic walk_tick;
        logic emit_status;
        logic load_ignore;
        logic ignore_val;
    } t_dp_cmd;

    typedef struct packed {
        logic ack_bad;
        logic active;
        logic slide_ok;
        logic out_free;
        logic idx_last;
    } t_dp_sts;

endpackage

[src/srsw_dp.sv]
// Datapath: window base, slot status/age registers, config and output word register.
// Depends on srsw_pkg and the core macros header.
`timescale 1ns / 1ps
`include "selective_repeat_sender_window_core_macros.svh"

module srsw_dp import srsw_pkg::*; #(
    parameter int WINDOW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SEQ_W-1:0]     i_cfg_data,
    input  logic [SEQ_W-1:0]     i_ack_seq,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_kind,
    output logic [SEQ_W-1:0]     o_seq,
    output logic                 o_is_last_packet,
    output logic                 o_is_retransmit,
    output logic [SEQ_W-1:0]     o_window_base,
    output logic                 o_done_res,
    output logic                 o_ack_ignored,
    output logic                 o_run_last
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [SEQ_W-1:0] r_cfg_pc, r_cfg_to;
    logic [SEQ_W-1:0] r_base, n_base;
    logic             r_active, r_ignored;
    logic [IDX_W-1:0] r_idx;
    t_slot_st         r_st  [WINDOW];
    logic [AGE_W-1:0] r_age [WINDOW];
    t_slot_st         n_st  [WINDOW];
    logic [AGE_W-1:0] n_age [WINDOW];
    t_slot_st         sh_st [WINDOW];
    logic [AGE_W-1:0] sh_age[WINDOW];

    logic             r_out_valid, r_kind, r_last, r_retx, r_done, r_ign_out, r_run_last;
    logic [SEQ_W-1:0] r_seq, r_base_out;

    logic [SEQ_W:0]   seq_cur, ack_diff;
    logic             in_range, done, out_free, slide_ok, walking;
    logic [AGE_W-1:0] age_inc, limit;
    logic             fire, issue_hit, tick_hit, step_emit;
    t_slot_st         head_st;
    logic [AGE_W-1:0] head_age;
    logic [IDX_W-1:0] mark_off;

    assign walking  = i_cmd.walk_new | i_cmd.walk_tick;
    assign seq_cur  = {1'b0, r_base} + (SEQ_W+1)'(r_idx);
    assign in_range = seq_cur < {1'b0, r_cfg_pc};
    assign ack_diff = {1'b0, i_ack_seq} - {1'b0, r_base};
    assign mark_off = ack_diff[IDX_W-1:0];
    assign done     = r_base >= r_cfg_pc;
    assign out_free = !r_out_valid || i_out_ready;
    assign slide_ok = (r_base < r_cfg_pc) && (r_st[0] == ST_ACKED);

    assign age_inc  = (r_age[0] == {AGE_W{1'b1}}) ? r_age[0] : r_age[0] + AGE_W'(1);
    assign limit    = (r_cfg_to == '0) ? AGE_W'(1) : r_cfg_to;
    assign fire     = age_inc >= limit;
    assign issue_hit = in_range && (r_st[0] == ST_NOT_SENT);
    assign tick_hit  = in_range && (r_st[0] == ST_SENT);
    assign step_emit = (i_cmd.walk_new && issue_hit) || (i_cmd.walk_tick && tick_hit && fire);

    always_comb begin
        head_st  = r_st[0];
        head_age = r_age[0];
        if (i_cmd.walk_new && issue_hit) begin
            head_st  = ST_SENT;
            head_age = '0;
        end else if (i_cmd.walk_tick && tick_hit) begin
            head_age = fire ? '0 : age_inc;
        end
    end

    for (genvar g = 0; g < WINDOW; g++) begin : g_slot
        if (g < WINDOW - 1) begin : g_mid
            assign sh_st[g]  = r_st[g+1];
            assign sh_age[g] = r_age[g+1];
        end else begin : g_top
            assign sh_st[g]  = walking ? head_st : ST_NOT_SENT;
            assign sh_age[g] = walking ? head_age : '0;
        end

        always_comb begin
            n_st[g]  = r_st[g];
            n_age[g] = r_age[g];
            if (i_cmd.clear) begin
                n_st[g]  = ST_NOT_SENT;
                n_age[g] = '0;
            end else if (i_cmd.mark && (mark_off == IDX_W'(g))) begin
                n_st[g]  = ST_ACKED;
            end else if (i_cmd.slide || walking) begin
                n_st[g]  = sh_st[g];
                n_age[g] = sh_age[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[g]  <= ST_NOT_SENT;
                r_age[g] <= '0;
            end else begin
                r_st[g]  <= n_st[g];
                r_age[g] <= n_age[g];
            end
        end
    end

    always_comb begin
        n_base = r_base;
        if (i_cmd.clear)
            n_base = '0;
        else if (i_cmd.slide)
            n_base = r_base + SEQ_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pc    <= PACKET_COUNT_RST;
            r_cfg_to    <= TIMEOUT_TICKS_RST;
            r_base      <= '0;
            r_active    <= 1'b0;
            r_ignored   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PACKET_COUNT:  r_cfg_pc <= i_cfg_data;
                    CFG_TIMEOUT_TICKS: r_cfg_to <= i_cfg_data;
                    default: ;
                endcase
            end
            r_base <= n_base;
            if (i_cmd.load_ignore)
                r_ignored <= i_cmd.ignore_val;
            if (i_cmd.clear)
                r_active <= 1'b1;
            else if (i_cmd.emit_status && done)
                r_active <= 1'b0;
            if (walking)
                r_idx <= (r_idx == IDX_W'(WINDOW - 1)) ? '0 : r_idx + IDX_W'(1);
            if (step_emit || i_cmd.emit_status)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            r_kind     <= KIND_STATUS;
            r_seq      <= '0;
            r_last     <= 1'b0;
            r_retx     <= 1'b0;
            r_run_last <= 1'b1;
        end else if (step_emit) begin
            r_kind     <= KIND_SEND;
            r_seq      <= seq_cur[SEQ_W-1:0];
            r_last     <= (seq_cur + (SEQ_W+1)'(1)) == {1'b0, r_cfg_pc};
            r_retx     <= i_cmd.walk_tick;
            r_run_last <= 1'b0;
        end
        if (i_cmd.emit_status || step_emit) begin
            r_base_out <= r_base;
            r_done     <= done;
            r_ign_out  <= r_ignored;
        end
    end

    assign o_sts.ack_bad  = !r_active || ack_diff[SEQ_W] || (i_ack_seq >= r_cfg_pc) ||
                            (ack_diff[SEQ_W-1:0] >= SEQ_W'(WINDOW));
    assign o_sts.active   = r_active;
    assign o_sts.slide_ok = slide_ok;
    assign o_sts.out_free = out_free;
    assign o_sts.idx_last = r_idx == IDX_W'(WINDOW - 1);

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_seq            = r_seq;
    assign o_is_last_packet = r_last;
    assign o_is_retransmit  = r_retx;
    assign o_window_base    = r_base_out;
    assign o_done_res       = r_done;
    assign o_ack_ignored    = r_ign_out;
    assign o_run_last       = r_run_last;

    `SRSW_ASSERT_SAME(a_slide_ok, i_clk, i_rst_n, i_cmd.slide, slide_ok, "slide without acked head")
    `SRSW_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, walking || i_cmd.emit_status, out_free, "step while output word held")
    `SRSW_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, i_cmd.emit_status && done, !r_active, "transfer still active after done")

endmodule

[src/srsw_ctrl.sv]
// Controller FSM: sequences accept, slide, slot walk and status word.
// Depends on srsw_pkg.
`timescale 1ns / 1ps

module srsw_ctrl import srsw_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_operation,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_SLIDE     = 5'b00010,
        S_WALK_NEW  = 5'b00100,
        S_WALK_TICK = 5'b01000,
        S_STATUS    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_ignore = 1'b1;
                    case (i_operation)
                        OP_START: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_WALK_NEW;
                        end
                        OP_ACK: begin
                            if (i_sts.ack_bad) begin
                                o_cmd.ignore_val = 1'b1;
                                n_state          = S_STATUS;
                            end else begin
                                o_cmd.mark = 1'b1;
                                n_state    = S_SLIDE;
                            end
                        end
                        OP_TICK: n_state = i_sts.active ? S_WALK_TICK : S_STATUS;
                        default: n_state = S_STATUS;
                    endcase
                end
            end
            S_SLIDE: begin
                if (i_sts.slide_ok)
                    o_cmd.slide = 1'b1;
                else
                    n_state = S_WALK_NEW;
            end
            S_WALK_NEW: begin
                if (i_sts.out_free) begin
                    o_cmd.walk_new = 1'b1;
                    if (i_sts.idx_last)
                        n_state = S_STATUS;
                end
            end
            S_WALK_TICK: begin
                if (i_sts.out_free) begin
                    o_cmd.walk_tick = 1'b1;
                    if (i_sts.idx_last)
                        n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

endmodule

[src/selective_repeat_sender_window_core.sv]
// Selective-repeat sender window core: controller and datapath, one word at a time.
// Start or active tick: accept, a slot walk over all WINDOW slots, then a status word.
// Valid ack: also a base slide per acked head slot and a slide check before the walk.
// Ignored ack, idle tick, unused op: accept, then status word. Output stalls hold the walk and status.
// Synchronous active-low reset: idle, base 0, all slots not sent, config back to defaults.
// Depends on srsw_pkg, srsw_ctrl, srsw_dp.
`timescale 1ns / 1ps

module selective_repeat_sender_window_core import srsw_pkg::*; #(
    parameter int WINDOW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SEQ_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [SEQ_W-1:0]     i_ack_seq,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [SEQ_W-1:0]     o_seq,
    output logic                 o_is_last_packet,
    output logic                 o_is_retransmit,
    output logic [SEQ_W-1:0]     o_window_base,
    output logic                 o_done_res,
    output logic                 o_ack_ignored,
    output logic                 o_run_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    srsw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    srsw_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_ack_seq        (i_ack_seq),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_seq            (o_seq),
        .o_is_last_packet (o_is_last_packet),
        .o_is_retransmit  (o_is_retransmit),
        .o_window_base    (o_window_base),
        .o_done_res       (o_done_res),
        .o_ack_ignored    (o_ack_ignored),
        .o_run_last       (o_run_last)
    );

endmodule
